>>> hw/rtl/qtr_pkg.sv
// qtr_pkg: shared constants, types and small functions of the trackball rotation block
// used by the channel interfaces, the controller, the datapath and the top level
`default_nettype none

package qtr_pkg;

  // fixed formats
  localparam int COORD_BITS   = 16;
  localparam int FRAC_BITS    = 30;
  localparam int CORDIC_STEPS = 24;
  localparam int CFG_BITS     = 25;
  localparam int CFG_IDX_BITS = 1;
  localparam int Q_BITS       = 32;
  localparam int OFF_BITS     = 42;   // (coord diff) x recip
  localparam int VEC_BITS     = 44;   // vectoring cordic x/y
  localparam int MAG_BITS     = 46;   // drag length
  localparam int ROT_BITS     = 34;   // rotation cordic x/y/z
  localparam int MUL_BITS     = 33;   // multiplier operand
  localparam int PROD_BITS    = 66;
  localparam int RND_BITS     = 36;   // rounded Q30 product
  localparam int ACC_BITS     = 38;
  localparam int MP_BITS      = 35;   // doubled matrix product
  localparam int SAT_BITS     = 40;
  localparam int DIV_STEPS    = 32;
  localparam int QUAT_TERMS   = 12;
  localparam int MAT_TERMS    = 9;
  localparam int CNT_BITS     = 5;

  localparam logic [29:0] GAIN_INV = 30'd652032874;
  localparam logic [CFG_BITS-1:0] RECIP_RESET = 25'd16384;
  localparam logic signed [Q_BITS-1:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RECIP_WIDTH  = 1'b0,
    REG_RECIP_HEIGHT = 1'b1
  } cfg_reg_t;

  // request codes
  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_MOTION = 2'd1,
    REQ_STOP   = 2'd2
  } req_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_START, S_OFFSET, S_VINIT, S_VEC, S_MAG, S_ZCHK,
    S_ROT, S_REND, S_NINIT, S_NORM, S_DINIT, S_DIV, S_DEND, S_DQ,
    S_QUAT, S_MAT, S_MOUT, S_COMMIT, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_START, OP_VEC_INIT, OP_VEC_STEP, OP_ROT_INIT,
    OP_ROT_STEP, OP_ROT_END, OP_NORM_INIT, OP_NORM_STEP, OP_DIV_INIT,
    OP_DIV_STEP, OP_DIV_END, OP_MAT_OUT, OP_COMMIT, OP_OUT
  } dp_op_t;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_DX, MUL_DY, MUL_MAG_HI, MUL_MAG_LO, MUL_DQ, MUL_QUAT, MUL_MAT
  } mul_op_t;

  typedef struct packed {
    dp_op_t              op;
    mul_op_t             mul_op;
    logic [CNT_BITS-1:0] idx;
    logic                sel;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       drag;
    logic       a_zero;
    logic       norm_busy;
  } dp_status_t;

  typedef logic [3:0][Q_BITS-1:0] quat_t;

  typedef struct packed {
    logic [Q_BITS-1:0] m00;
    logic [Q_BITS-1:0] m01;
    logic [Q_BITS-1:0] m02;
    logic [Q_BITS-1:0] m10;
    logic [Q_BITS-1:0] m11;
    logic [Q_BITS-1:0] m12;
    logic [Q_BITS-1:0] m20;
    logic [Q_BITS-1:0] m21;
    logic [Q_BITS-1:0] m22;
    logic              dragging;
  } result_t;

  // one term of the quaternion product
  typedef struct packed {
    logic [1:0] p_sel;
    logic [1:0] q_sel;
    logic       neg;
    logic       first;
    logic       last;
    logic [1:0] dst;
  } qterm_t;

  typedef struct packed {
    logic [1:0] a_sel;
    logic [1:0] b_sel;
  } mterm_t;

  // atan(2^-i) in turns, 32-bit fraction
  function automatic logic [31:0] atan_turn(input logic [CNT_BITS-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [Q_BITS-1:0] sat32(input logic signed [SAT_BITS-1:0] v);
    logic signed [Q_BITS-1:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[Q_BITS-1:0];
    end
    return r;
  endfunction

  // Q30 product, round half up
  function automatic logic signed [RND_BITS-1:0] mulq_rnd(
    input logic signed [PROD_BITS-1:0] p
  );
    logic signed [PROD_BITS-1:0] t;
    t = (p + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return t[RND_BITS-1:0];
  endfunction

  // (dq * committed) term order, w x y z of each result in turn
  function automatic qterm_t quat_term(input logic [CNT_BITS-1:0] i);
    qterm_t t;
    case (i)
      5'd0:  t = '{2'd0, 2'd0, 1'b0, 1'b1, 1'b0, 2'd0};
      5'd1:  t = '{2'd1, 2'd1, 1'b1, 1'b0, 1'b0, 2'd0};
      5'd2:  t = '{2'd2, 2'd2, 1'b1, 1'b0, 1'b1, 2'd0};
      5'd3:  t = '{2'd0, 2'd1, 1'b0, 1'b1, 1'b0, 2'd1};
      5'd4:  t = '{2'd1, 2'd0, 1'b0, 1'b0, 1'b0, 2'd1};
      5'd5:  t = '{2'd2, 2'd3, 1'b0, 1'b0, 1'b1, 2'd1};
      5'd6:  t = '{2'd0, 2'd2, 1'b0, 1'b1, 1'b0, 2'd2};
      5'd7:  t = '{2'd1, 2'd3, 1'b1, 1'b0, 1'b0, 2'd2};
      5'd8:  t = '{2'd2, 2'd0, 1'b0, 1'b0, 1'b1, 2'd2};
      5'd9:  t = '{2'd0, 2'd3, 1'b0, 1'b1, 1'b0, 2'd3};
      5'd10: t = '{2'd1, 2'd2, 1'b0, 1'b0, 1'b0, 2'd3};
      5'd11: t = '{2'd2, 2'd1, 1'b1, 1'b0, 1'b1, 2'd3};
      default: t = '0;
    endcase
    return t;
  endfunction

  // matrix products: xx yy zz xy yz zx xw yw zw
  function automatic mterm_t mat_term(input logic [CNT_BITS-1:0] i);
    mterm_t t;
    case (i)
      5'd0: t = '{2'd1, 2'd1};
      5'd1: t = '{2'd2, 2'd2};
      5'd2: t = '{2'd3, 2'd3};
      5'd3: t = '{2'd1, 2'd2};
      5'd4: t = '{2'd2, 2'd3};
      5'd5: t = '{2'd3, 2'd1};
      5'd6: t = '{2'd1, 2'd0};
      5'd7: t = '{2'd2, 2'd0};
      5'd8: t = '{2'd3, 2'd0};
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/qtr_in_if.sv
// qtr_in_if: pointer event channel, valid/ready with the event payload
// depends on qtr_pkg
`default_nettype none

interface qtr_in_if import qtr_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic signed [COORD_BITS-1:0] pointer_x;
  logic signed [COORD_BITS-1:0] pointer_y;

  modport source (output valid, output req_type, output pointer_x, output pointer_y,
                  input ready);
  modport sink (input valid, input req_type, input pointer_x, input pointer_y,
                output ready);
endinterface

`default_nettype wire

>>> hw/rtl/qtr_out_if.sv
// qtr_out_if: result channel, valid/ready with the rotation matrix and drag flag
// depends on qtr_pkg
`default_nettype none

interface qtr_out_if import qtr_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [Q_BITS-1:0] rot_m00;
  logic signed [Q_BITS-1:0] rot_m01;
  logic signed [Q_BITS-1:0] rot_m02;
  logic signed [Q_BITS-1:0] rot_m10;
  logic signed [Q_BITS-1:0] rot_m11;
  logic signed [Q_BITS-1:0] rot_m12;
  logic signed [Q_BITS-1:0] rot_m20;
  logic signed [Q_BITS-1:0] rot_m21;
  logic signed [Q_BITS-1:0] rot_m22;
  logic                     dragging;

  modport source (output valid, output rot_m00, output rot_m01, output rot_m02,
                  output rot_m10, output rot_m11, output rot_m12, output rot_m20,
                  output rot_m21, output rot_m22, output dragging, input ready);
  modport sink (input valid, input rot_m00, input rot_m01, input rot_m02,
                input rot_m10, input rot_m11, input rot_m12, input rot_m20,
                input rot_m21, input rot_m22, input dragging, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/qtr_ctrl.sv
// qtr_ctrl: sequencer of the trackball block, drives the datapath one step a cycle,
// holding while a result waits to be taken; depends on qtr_pkg
`default_nettype none

module qtr_ctrl import qtr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  state_t              state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                sel_r, sel_nxt;
  logic                out_valid_r, out_valid_nxt;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.op        = OP_NONE;
    cmd.mul_op    = MUL_NONE;
    cmd.idx       = cnt_r;
    cmd.sel       = sel_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cnt_nxt = '0;
        case (status.req)
          REQ_START:  state_nxt = S_START;
          REQ_MOTION: state_nxt = status.drag ? S_OFFSET : S_DONE;
          REQ_STOP:   state_nxt = status.drag ? S_OFFSET : S_COMMIT;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_START: begin
        cmd.op    = OP_START;
        state_nxt = S_DONE;
      end
      // offsets through the multiplier, then drained before the vectoring cordic
      S_OFFSET: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd0) begin
          cmd.mul_op = MUL_DX;
        end else if (cnt_r == 5'd1) begin
          cmd.mul_op = MUL_DY;
        end else begin
          state_nxt = S_VINIT;
        end
      end
      S_VINIT: begin
        cmd.op    = OP_VEC_INIT;
        cnt_nxt   = '0;
        state_nxt = S_VEC;
      end
      S_VEC: begin
        cmd.op  = OP_VEC_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(CORDIC_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_MAG;
        end
      end
      S_MAG: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd0) begin
          cmd.mul_op = MUL_MAG_HI;
        end else if (cnt_r == 5'd1) begin
          cmd.mul_op = MUL_MAG_LO;
        end else begin
          state_nxt = S_ZCHK;
        end
      end
      S_ZCHK: begin
        cnt_nxt = '0;
        if (status.a_zero) begin
          state_nxt = (status.req == REQ_STOP) ? S_COMMIT : S_DONE;
        end else begin
          cmd.op    = OP_ROT_INIT;
          state_nxt = S_ROT;
        end
      end
      S_ROT: begin
        cmd.op  = OP_ROT_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(CORDIC_STEPS - 1)) begin
          state_nxt = S_REND;
        end
      end
      S_REND: begin
        cmd.op    = OP_ROT_END;
        sel_nxt   = 1'b0;
        state_nxt = S_NINIT;
      end
      // ratio: first dy/a, then dx/a
      S_NINIT: begin
        cmd.op    = OP_NORM_INIT;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (status.norm_busy) begin
          cmd.op = OP_NORM_STEP;
        end else begin
          state_nxt = S_DINIT;
        end
      end
      S_DINIT: begin
        cmd.op    = OP_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(DIV_STEPS - 1)) begin
          state_nxt = S_DEND;
        end
      end
      S_DEND: begin
        cmd.op  = OP_DIV_END;
        cnt_nxt = '0;
        if (!sel_r) begin
          sel_nxt   = 1'b1;
          state_nxt = S_NINIT;
        end else begin
          state_nxt = S_DQ;
        end
      end
      S_DQ: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd0) begin
          cmd.mul_op = MUL_DQ;
          cmd.sel    = 1'b0;
        end else if (cnt_r == 5'd1) begin
          cmd.mul_op = MUL_DQ;
          cmd.sel    = 1'b1;
        end else begin
          cnt_nxt   = '0;
          state_nxt = S_QUAT;
        end
      end
      S_QUAT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r < CNT_BITS'(QUAT_TERMS)) begin
          cmd.mul_op = MUL_QUAT;
        end else begin
          cnt_nxt   = '0;
          state_nxt = S_MAT;
        end
      end
      S_MAT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r < CNT_BITS'(MAT_TERMS)) begin
          cmd.mul_op = MUL_MAT;
        end else begin
          state_nxt = S_MOUT;
        end
      end
      S_MOUT: begin
        cmd.op    = OP_MAT_OUT;
        state_nxt = (status.req == REQ_STOP) ? S_COMMIT : S_DONE;
      end
      S_COMMIT: begin
        cmd.op    = OP_COMMIT;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted item not decoded");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");
  a_rot_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT || state_r == S_VEC) |-> (cnt_r < CNT_BITS'(CORDIC_STEPS)))
    else $error("cordic step count overrun");
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (state_r == S_IDLE && !out_valid_r))
    else $error("reset did not return to idle");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/qtr_dp.sv
// qtr_dp: datapath of the trackball block: shared 33x33 multiplier, two cordics,
// a restoring divider and the quaternion, matrix and result registers; depends on qtr_pkg
`default_nettype none

module qtr_dp import qtr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [CFG_BITS-1:0]          cfg_data,
  input  logic [1:0]                   in_req,
  input  logic signed [COORD_BITS-1:0] in_px,
  input  logic signed [COORD_BITS-1:0] in_py,
  input  ctl_cmd_t                     cmd,
  output dp_status_t                   status,
  output result_t                      result
);

  logic [CFG_BITS-1:0]          recip_w_r, recip_h_r;
  logic [1:0]                   req_r;
  logic signed [COORD_BITS-1:0] px_r, py_r, ax_r, ay_r;
  logic                         drag_r;
  quat_t                        committed_r, working_r;
  logic signed [Q_BITS-1:0]     m_r [MAT_TERMS];
  logic signed [OFF_BITS-1:0]   dx_r, dy_r;
  logic signed [VEC_BITS-1:0]   vx_r, vy_r;
  logic [MAG_BITS-1:0]          a_r;
  logic signed [ROT_BITS-1:0]   rx_r, ry_r, rz_r;
  logic                         flip_r;
  logic signed [Q_BITS-1:0]     c_r, s_r;
  logic [MAG_BITS-1:0]          an_r;
  logic signed [OFF_BITS-1:0]   dn_r;
  logic [32:0]                  rem_r;
  logic [31:0]                  dbits_r, quo_r;
  logic                         neg_r, ovf_r;
  logic signed [Q_BITS-1:0]     ratio_x_r, ratio_y_r, dq1_r, dq2_r;
  logic signed [ACC_BITS-1:0]   acc_r;
  logic signed [MP_BITS-1:0]    mp_r [MAT_TERMS];
  logic signed [PROD_BITS-1:0]  prod_r;
  mul_op_t                      mul_op_r;
  logic [CNT_BITS-1:0]          midx_r;
  result_t                      out_r;

  logic signed [COORD_BITS:0]   offx, offy;
  logic signed [MUL_BITS-1:0]   ma, mb;
  qterm_t                       qt_iss, qt_use;
  mterm_t                       mt_iss;

  // vectoring cordic step
  logic signed [VEC_BITS-1:0]   vxs, vys, vx_nxt, vy_nxt;
  logic signed [OFF_BITS-1:0]   dx_abs;
  // rotation cordic
  logic signed [ROT_BITS-1:0]   rxs, rys, rx_nxt, ry_nxt, rz_nxt, at, z0;
  logic signed [31:0]           phase;
  // divider
  logic signed [OFF_BITS-1:0]   dn_clamp, dn_neg;
  logic [32:0]                  dmag;
  logic [33:0]                  dtrial;
  logic                         dge;
  logic [31:0]                  qmag;
  logic signed [Q_BITS-1:0]     ratio;
  // product use
  logic signed [RND_BITS-1:0]   prnd;
  logic signed [ACC_BITS-1:0]   acc_nxt, term;
  logic signed [SAT_BITS-1:0]   one_w;

  assign status.req       = req_r;
  assign status.drag      = drag_r;
  assign status.a_zero    = (a_r == '0);
  assign status.norm_busy = (an_r[MAG_BITS-1:32] != '0);
  assign result           = out_r;

  assign offx = {px_r[COORD_BITS-1], px_r} - {ax_r[COORD_BITS-1], ax_r};
  assign offy = {py_r[COORD_BITS-1], py_r} - {ay_r[COORD_BITS-1], ay_r};

  assign qt_iss = quat_term(cmd.idx);
  assign qt_use = quat_term(midx_r);
  assign mt_iss = mat_term(cmd.idx);

  // multiplier operand selection
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul_op)
      MUL_DX: begin
        ma = MUL_BITS'(offx);
        mb = {8'd0, recip_w_r};
      end
      MUL_DY: begin
        ma = MUL_BITS'(offy);
        mb = {8'd0, recip_h_r};
      end
      MUL_MAG_HI: begin
        ma = {20'd0, vx_r[42:30]};
        mb = {3'd0, GAIN_INV};
      end
      MUL_MAG_LO: begin
        ma = {3'd0, vx_r[29:0]};
        mb = {3'd0, GAIN_INV};
      end
      MUL_DQ: begin
        ma = cmd.sel ? MUL_BITS'(ratio_x_r) : MUL_BITS'(ratio_y_r);
        mb = MUL_BITS'(s_r);
      end
      MUL_QUAT: begin
        case (qt_iss.p_sel)
          2'd0:    ma = MUL_BITS'(c_r);
          2'd1:    ma = MUL_BITS'(dq1_r);
          default: ma = MUL_BITS'(dq2_r);
        endcase
        mb = MUL_BITS'($signed(committed_r[qt_iss.q_sel]));
      end
      MUL_MAT: begin
        ma = MUL_BITS'($signed(working_r[mt_iss.a_sel]));
        mb = MUL_BITS'($signed(working_r[mt_iss.b_sel]));
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // cordic and divider step logic
  always_comb begin
    vxs    = vx_r >>> cmd.idx;
    vys    = vy_r >>> cmd.idx;
    vx_nxt = (vy_r >= 0) ? vx_r + vys : vx_r - vys;
    vy_nxt = (vy_r >= 0) ? vy_r - vxs : vy_r + vxs;
    dx_abs = (dx_r < 0) ? -dx_r : dx_r;

    rxs    = rx_r >>> cmd.idx;
    rys    = ry_r >>> cmd.idx;
    at     = $signed({2'b00, atan_turn(cmd.idx)});
    rx_nxt = (rz_r >= 0) ? rx_r - rys : rx_r + rys;
    ry_nxt = (rz_r >= 0) ? ry_r + rxs : ry_r - rxs;
    rz_nxt = (rz_r >= 0) ? rz_r - at : rz_r + at;
    phase  = $signed({a_r[24:0], 7'd0});
    z0     = ROT_BITS'(phase);

    if (dn_r > (42'sd1 <<< 32)) begin
      dn_clamp = 42'sd1 <<< 32;
    end else if (dn_r < -(42'sd1 <<< 32)) begin
      dn_clamp = -(42'sd1 <<< 32);
    end else begin
      dn_clamp = dn_r;
    end
    dn_neg = -dn_clamp;
    dmag   = (dn_clamp < 0) ? dn_neg[32:0] : dn_clamp[32:0];
    dtrial = {rem_r, dbits_r[31]};
    dge    = dtrial >= {2'b00, an_r[31:0]};
    qmag   = (ovf_r || quo_r > 32'h40000000) ? 32'h40000000 : quo_r;
    ratio  = neg_r ? -$signed(qmag) : $signed(qmag);

    prnd    = mulq_rnd(prod_r);
    term    = qt_use.neg ? -ACC_BITS'(prnd) : ACC_BITS'(prnd);
    acc_nxt = (qt_use.first ? '0 : acc_r) + term;
    one_w   = SAT_BITS'(ONE_Q);
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recip_w_r   <= RECIP_RESET;
      recip_h_r   <= RECIP_RESET;
      drag_r      <= 1'b0;
      ax_r        <= '0;
      ay_r        <= '0;
      committed_r <= {32'd0, 32'd0, 32'd0, ONE_Q};
      working_r   <= {32'd0, 32'd0, 32'd0, ONE_Q};
      for (int i = 0; i < MAT_TERMS; i++) begin
        m_r[i] <= (i % 4 == 0) ? ONE_Q : '0;
      end
      mul_op_r    <= MUL_NONE;
      midx_r      <= '0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_RECIP_WIDTH:  recip_w_r <= cfg_data;
          REG_RECIP_HEIGHT: recip_h_r <= cfg_data;
          default: ;
        endcase
      end

      // product pipeline
      prod_r   <= ma * mb;
      mul_op_r <= cmd.mul_op;
      midx_r   <= cmd.idx;
      case (mul_op_r)
        MUL_DX:     dx_r <= prod_r[OFF_BITS-1:0];
        MUL_DY:     dy_r <= prod_r[OFF_BITS-1:0];
        MUL_MAG_HI: a_r  <= prod_r[MAG_BITS-1:0];
        MUL_MAG_LO: a_r  <= a_r + {14'd0, prod_r[61:30]};
        MUL_DQ: begin
          if (midx_r == '0) begin
            dq1_r <= sat32(SAT_BITS'(prnd));
          end else begin
            dq2_r <= sat32(SAT_BITS'(prnd));
          end
        end
        MUL_QUAT: begin
          acc_r <= acc_nxt;
          if (qt_use.last) begin
            working_r[qt_use.dst] <= sat32(SAT_BITS'(acc_nxt));
          end
        end
        MUL_MAT: mp_r[midx_r[3:0]] <= {prnd[MP_BITS-2:0], 1'b0};
        default: ;
      endcase

      // sequenced operations
      case (cmd.op)
        OP_LOAD: begin
          req_r <= in_req;
          px_r  <= in_px;
          py_r  <= in_py;
        end
        OP_START: begin
          drag_r    <= 1'b1;
          ax_r      <= px_r;
          ay_r      <= py_r;
          working_r <= committed_r;
        end
        OP_VEC_INIT: begin
          vx_r <= VEC_BITS'(dx_abs);
          vy_r <= VEC_BITS'(dy_r);
        end
        OP_VEC_STEP: begin
          vx_r <= vx_nxt;
          vy_r <= vy_nxt;
        end
        OP_ROT_INIT: begin
          rx_r <= ROT_BITS'(GAIN_INV);
          ry_r <= '0;
          if (z0 > (34'sd1 <<< 30) || z0 < -(34'sd1 <<< 30)) begin
            rz_r   <= (z0 > 0) ? z0 - (34'sd1 <<< 31) : z0 + (34'sd1 <<< 31);
            flip_r <= 1'b1;
          end else begin
            rz_r   <= z0;
            flip_r <= 1'b0;
          end
        end
        OP_ROT_STEP: begin
          rx_r <= rx_nxt;
          ry_r <= ry_nxt;
          rz_r <= rz_nxt;
        end
        OP_ROT_END: begin
          c_r <= sat32(SAT_BITS'(flip_r ? -rx_r : rx_r));
          s_r <= sat32(SAT_BITS'(flip_r ? -ry_r : ry_r));
        end
        OP_NORM_INIT: begin
          an_r <= a_r;
          dn_r <= cmd.sel ? dx_r : dy_r;
        end
        OP_NORM_STEP: begin
          an_r <= an_r >> 1;
          dn_r <= dn_r >>> 1;
        end
        OP_DIV_INIT: begin
          neg_r   <= dn_clamp < 0;
          ovf_r   <= {1'b0, dmag} >= {an_r[31:0], 2'b00};
          rem_r   <= {2'b00, dmag[32:2]};
          dbits_r <= {dmag[1:0], 30'd0};
          quo_r   <= '0;
        end
        OP_DIV_STEP: begin
          rem_r   <= dge ? 33'(dtrial - {2'b00, an_r[31:0]}) : dtrial[32:0];
          dbits_r <= {dbits_r[30:0], 1'b0};
          quo_r   <= {quo_r[30:0], dge};
        end
        OP_DIV_END: begin
          if (cmd.sel) begin
            ratio_x_r <= (an_r == '0) ? '0 : ratio;
          end else begin
            ratio_y_r <= (an_r == '0) ? '0 : ratio;
          end
        end
        OP_MAT_OUT: begin
          m_r[0] <= sat32(one_w - SAT_BITS'(mp_r[1]) - SAT_BITS'(mp_r[2]));
          m_r[1] <= sat32(SAT_BITS'(mp_r[3]) + SAT_BITS'(mp_r[8]));
          m_r[2] <= sat32(SAT_BITS'(mp_r[5]) - SAT_BITS'(mp_r[7]));
          m_r[3] <= sat32(SAT_BITS'(mp_r[3]) - SAT_BITS'(mp_r[8]));
          m_r[4] <= sat32(one_w - SAT_BITS'(mp_r[2]) - SAT_BITS'(mp_r[0]));
          m_r[5] <= sat32(SAT_BITS'(mp_r[4]) + SAT_BITS'(mp_r[6]));
          m_r[6] <= sat32(SAT_BITS'(mp_r[5]) + SAT_BITS'(mp_r[7]));
          m_r[7] <= sat32(SAT_BITS'(mp_r[4]) - SAT_BITS'(mp_r[6]));
          m_r[8] <= sat32(one_w - SAT_BITS'(mp_r[0]) - SAT_BITS'(mp_r[1]));
        end
        OP_COMMIT: begin
          committed_r <= working_r;
          drag_r      <= 1'b0;
        end
        OP_OUT: begin
          out_r.m00      <= m_r[0];
          out_r.m01      <= m_r[1];
          out_r.m02      <= m_r[2];
          out_r.m10      <= m_r[3];
          out_r.m11      <= m_r[4];
          out_r.m12      <= m_r[5];
          out_r.m20      <= m_r[6];
          out_r.m21      <= m_r[7];
          out_r.m22      <= m_r[8];
          out_r.dragging <= drag_r;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/quaternion_trackball_rotation.sv
// quaternion_trackball_rotation: top level, joins controller, datapath and channels
// depends on qtr_pkg, qtr_in_if, qtr_out_if, qtr_ctrl, qtr_dp
//
// channel   direction  handshake    payload
// in_chan   in         valid/ready  req_type, pointer_x, pointer_y
// out_chan  out        valid/ready  rot_m00..rot_m22, dragging
// cfg_*     in         cfg_we       cfg_index, cfg_data (25 bits)
//
// one item at a time: a start, a stop with no drag, a motion with no drag or an unused code
// skips the arithmetic; a zero drag length ends after the length (a stop then also commits);
// the time of a motion with a nonzero drag (a stop also commits) is set by the two
// 24-step cordics, two 32-step restoring divides with up to 10 normalising shifts each, and
// 27 products through the one shared 33x33 multiplier
// synchronous active-low reset restores the identity rotation and default reciprocals
// the next item is taken while a result waits; a result is held until taken
`default_nettype none

module quaternion_trackball_rotation import qtr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  qtr_in_if.sink                  in_chan,
  qtr_out_if.source               out_chan,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  ctl_cmd_t   cmd;
  dp_status_t status;
  result_t    result;

  // sequencer
  qtr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic and state
  qtr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_req    (in_chan.req_type),
    .in_px     (in_chan.pointer_x),
    .in_py     (in_chan.pointer_y),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

  // result item
  assign out_chan.rot_m00  = result.m00;
  assign out_chan.rot_m01  = result.m01;
  assign out_chan.rot_m02  = result.m02;
  assign out_chan.rot_m10  = result.m10;
  assign out_chan.rot_m11  = result.m11;
  assign out_chan.rot_m12  = result.m12;
  assign out_chan.rot_m20  = result.m20;
  assign out_chan.rot_m21  = result.m21;
  assign out_chan.rot_m22  = result.m22;
  assign out_chan.dragging = result.dragging;

endmodule

`default_nettype wire
